// ----- hdl/sv39ptw_pkg.sv -----
// Package for the Sv39 page table walker: sizes, status codes and the
// command and status structs between controller and datapath.
// No dependencies.
package sv39ptw_pkg;

  localparam int POOL_PAGES       = 8;
  localparam int ENTRIES_PER_PAGE = 512;
  localparam int VPN_W            = $clog2(ENTRIES_PER_PAGE);
  localparam int PAGE_W           = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int DEPTH            = POOL_PAGES * ENTRIES_PER_PAGE;
  localparam int ADDR_W           = $clog2(DEPTH);
  localparam int NF_W             = $clog2(POOL_PAGES + 1);

  localparam int PG_SHIFT    = 12;
  localparam int PTE_PPN_LSB = 10;
  localparam int PPN_W       = 44;
  localparam int PTE_W       = 64;
  localparam int VA_W        = 39;
  localparam int PA_W        = 56;
  localparam int PERM_W      = 8;
  localparam int ST_W        = 3;
  localparam int LVL_W       = 2;

  localparam int PTE_V_BIT          = 0;
  localparam logic [PERM_W-1:0] PTE_RWX = 8'h0E;
  localparam logic [PERM_W-1:0] PTE_V   = 8'h01;

  localparam int IN_W  = 104;
  localparam int OUT_W = 72;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_MISALIGN  = 3'd1;
  localparam logic [ST_W-1:0] ST_SUPER     = 3'd2;
  localparam logic [ST_W-1:0] ST_EXHAUST   = 3'd3;
  localparam logic [ST_W-1:0] ST_MAPPED    = 3'd4;
  localparam logic [ST_W-1:0] ST_NOTMAPPED = 3'd5;

  localparam logic [1:0] ENT_ZERO = 2'd0;
  localparam logic [1:0] ENT_READ = 2'd1;
  localparam logic [1:0] ENT_LEAF = 2'd2;

  localparam logic [LVL_W-1:0] LVL_TOP = 2'd2;

  typedef struct packed {
    logic            clr_en;
    logic            load;
    logic            rd_en;
    logic            descend;
    logic            alloc;
    logic            wr_leaf;
    logic            finish;
    logic [ST_W-1:0] fin_status;
    logic [1:0]      fin_src;
    logic            out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic op_map;
    logic misalign;
    logic level0;
    logic ent_v;
    logic ent_rwx;
    logic in_pool;
    logic pool_full;
    logic out_busy;
  } dp_sts_t;

endpackage

// ----- hdl/sv39ptw_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
module sv39ptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/sv39ptw_dp.sv -----
// Datapath of the Sv39 walker: item registers, walk pointers, free page
// counter, table memory and output register. Uses sv39ptw_pkg, sv39ptw_ram.
module sv39ptw_dp
  import sv39ptw_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  input  logic                cfg_wr_en,
  input  logic [PPN_W-1:0]    cfg_wr_data,
  input  logic [IN_W-1:0]     in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_W-1:0]    out_tdata
);

  logic [PPN_W-1:0]  base_r;
  logic              op_r;
  logic [VA_W-1:0]   va_r;
  logic [PA_W-1:0]   pa_r;
  logic [PERM_W-1:0] perm_r;
  logic [PAGE_W-1:0] page_r;
  logic [LVL_W-1:0]  lvl_r;
  logic [NF_W-1:0]   nf_r;
  logic [ADDR_W-1:0] clr_cnt_r;

  logic [ST_W-1:0]   res_status_r;
  logic [PTE_W-1:0]  res_entry_r;
  logic [LVL_W-1:0]  res_level_r;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;

  logic [VPN_W-1:0]  vidx;
  logic [ADDR_W-1:0] cur_addr;
  logic [PTE_W-1:0]  rd_data;
  logic [PPN_W-1:0]  rel;
  logic [PTE_W-1:0]  ptr_entry;
  logic [PTE_W-1:0]  leaf_entry;
  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_wr_addr;
  logic [PTE_W-1:0]  mem_wr_data;

  always_comb begin
    case (lvl_r)
      2'd2:    vidx = va_r[PG_SHIFT + 2*VPN_W +: VPN_W];
      2'd1:    vidx = va_r[PG_SHIFT + VPN_W +: VPN_W];
      default: vidx = va_r[PG_SHIFT +: VPN_W];
    endcase
  end

  assign cur_addr   = ADDR_W'({page_r, vidx});
  assign rel        = rd_data[PTE_PPN_LSB +: PPN_W] - base_r;
  assign ptr_entry  = {10'd0, base_r + PPN_W'(nf_r), 10'd1};
  assign leaf_entry = {10'd0, pa_r[PG_SHIFT +: PPN_W], 2'b00, perm_r | PTE_V};

  always_comb begin
    mem_wr_en   = cmd.clr_en | cmd.alloc | cmd.wr_leaf;
    mem_wr_addr = cur_addr;
    mem_wr_data = leaf_entry;
    if (cmd.clr_en) begin
      mem_wr_addr = clr_cnt_r;
      mem_wr_data = '0;
    end else if (cmd.alloc) begin
      mem_wr_data = ptr_entry;
    end
  end

  sv39ptw_ram #(
    .WIDTH(PTE_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (cmd.rd_en),
    .rd_addr(cur_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    sts.clr_last  = (clr_cnt_r == ADDR_W'(DEPTH - 1));
    sts.op_map    = op_r;
    sts.misalign  = op_r && ((va_r[PG_SHIFT-1:0] != '0) || (pa_r[PG_SHIFT-1:0] != '0));
    sts.level0    = (lvl_r == '0);
    sts.ent_v     = rd_data[PTE_V_BIT];
    sts.ent_rwx   = (rd_data[PERM_W-1:0] & PTE_RWX) != '0;
    sts.in_pool   = (rel < PPN_W'(POOL_PAGES));
    sts.pool_full = (nf_r >= NF_W'(POOL_PAGES));
    sts.out_busy  = out_valid_r && !out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      nf_r        <= NF_W'(1);
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
      if (cmd.alloc) begin
        nf_r <= nf_r + NF_W'(1);
      end
      if (cmd.clr_en) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_tdata[0];
      va_r   <= in_tdata[39:1];
      pa_r   <= in_tdata[95:40];
      perm_r <= in_tdata[103:96];
      page_r <= '0;
      lvl_r  <= LVL_TOP;
    end else if (cmd.descend) begin
      page_r <= rel[PAGE_W-1:0];
      lvl_r  <= lvl_r - LVL_W'(1);
    end else if (cmd.alloc) begin
      page_r <= nf_r[PAGE_W-1:0];
      lvl_r  <= lvl_r - LVL_W'(1);
    end
    if (cmd.finish) begin
      res_status_r <= cmd.fin_status;
      case (cmd.fin_src)
        ENT_READ: begin
          res_entry_r <= rd_data;
          res_level_r <= lvl_r;
        end
        ENT_LEAF: begin
          res_entry_r <= leaf_entry;
          res_level_r <= '0;
        end
        default: begin
          res_entry_r <= '0;
          res_level_r <= '0;
        end
      endcase
    end
    if (cmd.out_load) begin
      out_data_r <= {3'b000, res_level_r, res_entry_r, res_status_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_nf_range: assert property (@(posedge clk) disable iff (!rst_n)
    (nf_r != '0) && (nf_r <= NF_W'(POOL_PAGES)))
    else $error("Free page counter left its range.");

  a_load_root: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (lvl_r == LVL_TOP) && (page_r == '0))
    else $error("Walk did not start at the root page.");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.out_busy)
    else $error("Result loaded over an unaccepted word.");

endmodule

// ----- hdl/sv39ptw_ctrl.sv -----
// Controller of the Sv39 walker: clearing sweep, walk sequencing and the
// decision at each level. Uses sv39ptw_pkg.
module sv39ptw_ctrl
  import sv39ptw_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (sts.misalign) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_MISALIGN;
          state_nxt      = S_DONE;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_DONE;
        cmd.finish = 1'b1;
        if (sts.op_map) begin
          if (!sts.level0) begin
            if (sts.ent_v) begin
              if (sts.ent_rwx || !sts.in_pool) begin
                cmd.fin_status = ST_SUPER;
              end else begin
                cmd.finish  = 1'b0;
                cmd.descend = 1'b1;
                state_nxt   = S_RD;
              end
            end else if (sts.pool_full) begin
              cmd.fin_status = ST_EXHAUST;
            end else begin
              cmd.finish = 1'b0;
              cmd.alloc  = 1'b1;
              state_nxt  = S_RD;
            end
          end else if (sts.ent_v && sts.ent_rwx) begin
            cmd.fin_status = ST_MAPPED;
          end else begin
            cmd.wr_leaf    = 1'b1;
            cmd.fin_status = ST_OK;
            cmd.fin_src    = ENT_LEAF;
          end
        end else begin
          if (!sts.ent_v) begin
            cmd.fin_status = ST_NOTMAPPED;
          end else if (sts.level0 || sts.ent_rwx) begin
            cmd.fin_status = ST_OK;
            cmd.fin_src    = ENT_READ;
          end else if (!sts.in_pool) begin
            cmd.fin_status = ST_NOTMAPPED;
          end else begin
            cmd.finish  = 1'b0;
            cmd.descend = 1'b1;
            state_nxt   = S_RD;
          end
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc |-> !sts.pool_full && !sts.ent_v && !sts.level0)
    else $error("Page taken without need or with the pool used up.");

  a_leaf_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_leaf |-> sts.op_map && sts.level0 && !(sts.ent_v && sts.ent_rwx))
    else $error("Leaf written outside a valid map at level 0.");

  a_eval_next: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |=> (state_r == S_RD) || (state_r == S_DONE))
    else $error("Evaluation led to an unexpected state.");

endmodule

// ----- hdl/sv39_page_table_map_walk.sv -----
// Top level of the Sv39 page table keeper and walker.
// Joins sv39ptw_ctrl and sv39ptw_dp; uses sv39ptw_pkg.
//
//   channel   dir  handshake             payload
//   in_       in   in_tvalid/in_tready   in_tdata[103:0]
//   out_      out  out_tvalid/out_tready out_tdata[71:0]
//   cfg_      in   cfg_wr_en             cfg_wr_data[43:0]
//
// An item is accepted, then each table level walked takes a memory read and then
// an evaluate and write step, set by the single registered read port of the table
// memory; last the result is loaded once the output register is free.
// After reset the table memory is cleared one entry a cycle, all 4096 entries,
// during which no word is accepted; configuration writes are taken.
// A new word is accepted while a result word still waits on the output.
module sv39_page_table_map_walk
  import sv39ptw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [PPN_W-1:0]   cfg_wr_data,  // pool_base_ppn
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [IN_W-1:0]    in_tdata,     // operation, virt_addr, phys_addr, perm_bits
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_W-1:0]   out_tdata     // status, entry_value, leaf_level, zero pad
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  sv39ptw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sv39ptw_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- tb/sv/tb_sv39_walk_pkg.sv -----
// Word layouts and a scoreboard class for the Sv39 page table walker testbench.
// The class keeps a shadow of the table pool and predicts every result word.
// Depends on sv39ptw_pkg.
`timescale 1ns / 1ps
package tb_sv39_walk_pkg;
  import sv39ptw_pkg::*;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_MAP    = 1'b1;

  typedef struct packed {
    logic [PERM_W-1:0] perm;
    logic [PA_W-1:0]   pa;
    logic [VA_W-1:0]   va;
    logic              op;
  } walk_req_t;

  typedef struct packed {
    logic [OUT_W-LVL_W-PTE_W-ST_W-1:0] pad;
    logic [LVL_W-1:0]                  level;
    logic [PTE_W-1:0]                  entry;
    logic [ST_W-1:0]                   status;
  } walk_resp_t;

  class sv39_table_shadow;
    logic [PTE_W-1:0] pool [DEPTH];
    int unsigned      next_page;
    logic [PPN_W-1:0] base_ppn;
    walk_resp_t       due[$];
    logic [VA_W-1:0]  mapped_va[$];
    int unsigned      errors;
    int unsigned      seen;

    function new();
      foreach (pool[i]) pool[i] = '0;
      next_page = 1;
      base_ppn  = '0;
      errors    = 0;
      seen      = 0;
    endfunction

    function void set_base(logic [PPN_W-1:0] v);
      base_ppn = v;
    endfunction

    function logic [ADDR_W-1:0] slot(int page, logic [VA_W-1:0] va, int lvl);
      logic [VPN_W-1:0] idx;
      idx = va[PG_SHIFT + VPN_W * lvl +: VPN_W];
      return ADDR_W'(page * ENTRIES_PER_PAGE + idx);
    endfunction

    function bit has_rwx(logic [PTE_W-1:0] e);
      return |(e[PERM_W-1:0] & PTE_RWX);
    endfunction

    // Pool page named by a pointer entry, or -1 when it falls outside the pool.
    function int pool_index(logic [PTE_W-1:0] e);
      logic [PPN_W-1:0] rel;
      rel = e[PTE_PPN_LSB +: PPN_W] - base_ppn;
      if (rel >= PPN_W'(POOL_PAGES)) return -1;
      return int'(rel);
    endfunction

    function walk_resp_t predict(walk_req_t r);
      walk_resp_t        rs;
      logic [PTE_W-1:0]  e;
      logic [ADDR_W-1:0] s;
      int                page;
      int                lvl;
      rs = '0;
      rs.status = ST_OK;
      page = 0;
      if (r.op == OP_MAP) begin
        if (r.va[PG_SHIFT-1:0] != '0 || r.pa[PG_SHIFT-1:0] != '0) begin
          rs.status = ST_MISALIGN;
          return rs;
        end
        for (lvl = LVL_TOP; lvl > 0; lvl--) begin
          s = slot(page, r.va, lvl);
          e = pool[s];
          if (e[PTE_V_BIT]) begin
            if (has_rwx(e)) begin
              rs.status = ST_SUPER;
              return rs;
            end
            page = pool_index(e);
            if (page < 0) begin
              rs.status = ST_SUPER;
              return rs;
            end
          end else if (next_page >= POOL_PAGES) begin
            rs.status = ST_EXHAUST;
            return rs;
          end else begin
            e = '0;
            e[PTE_PPN_LSB +: PPN_W] = base_ppn + PPN_W'(next_page);
            e[PTE_V_BIT] = 1'b1;
            pool[s] = e;
            page = next_page;
            next_page++;
          end
        end
        s = slot(page, r.va, 0);
        if (pool[s][PTE_V_BIT] && has_rwx(pool[s])) begin
          rs.status = ST_MAPPED;
          return rs;
        end
        e = '0;
        e[PTE_PPN_LSB +: PPN_W] = r.pa[PG_SHIFT +: PPN_W];
        e[PERM_W-1:0] = r.perm | PTE_V;
        pool[s] = e;
        rs.entry = e;
        mapped_va.push_back(r.va);
        return rs;
      end
      for (lvl = LVL_TOP; lvl > 0; lvl--) begin
        e = pool[slot(page, r.va, lvl)];
        if (!e[PTE_V_BIT]) begin
          rs.status = ST_NOTMAPPED;
          return rs;
        end
        if (has_rwx(e)) begin
          rs.entry = e;
          rs.level = LVL_W'(lvl);
          return rs;
        end
        page = pool_index(e);
        if (page < 0) begin
          rs.status = ST_NOTMAPPED;
          return rs;
        end
      end
      e = pool[slot(page, r.va, 0)];
      if (!e[PTE_V_BIT]) rs.status = ST_NOTMAPPED;
      else rs.entry = e;
      return rs;
    endfunction

    function void take_request(walk_req_t r);
      due.push_back(predict(r));
    endfunction

    function void match_response(walk_resp_t got);
      walk_resp_t want;
      seen++;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result %0d arrived with nothing outstanding: status %0d entry %h level %0d",
                   seen, got.status, got.entry, got.level);
        return;
      end
      want = due.pop_front();
      if (got.status !== want.status || got.entry !== want.entry ||
          got.level !== want.level) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: status %0d/%0d entry %h/%h level %0d/%0d (expected/actual)",
                   seen, want.status, got.status, want.entry, got.entry,
                   want.level, got.level);
      end
    endfunction
  endclass

endpackage

// ----- tb/sv/tb_sv39_page_table_map_walk.sv -----
// Top of the Sv39 page table walker testbench: clock, reset, stream drivers
// and monitors around sv39_page_table_map_walk. Uses sv39ptw_pkg and
// tb_sv39_walk_pkg for word layouts and the scoreboard.
`timescale 1ns / 1ps
module tb_sv39_page_table_map_walk;
  import sv39ptw_pkg::*;
  import tb_sv39_walk_pkg::*;

  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 100;
  localparam int SETTLE      = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [PPN_W-1:0] PPN_TOP = '1;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [PPN_W-1:0] cfg_wr_data;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;

  sv39_table_shadow shadow;
  int               idle_odds = 0;
  int               phase_odds [PHASES] = '{4, 0, 2, 6, 3, 0};
  int unsigned      cycles = 0;

  sv39_page_table_map_walk dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("sv39_page_table_map_walk: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) shadow.match_response(out_tdata);
      if (in_tvalid && in_tready) shadow.take_request(in_tdata);
      if (cfg_wr_en) shadow.set_base(cfg_wr_data);
    end
  end

  initial begin : out_ready_gen
    int hold;
    hold = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        hold = $urandom_range(0, 11);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic walk_req_t word(logic op, logic [VA_W-1:0] va, logic [PA_W-1:0] pa,
                                     logic [PERM_W-1:0] perm);
    walk_req_t r;
    r.op   = op;
    r.va   = va;
    r.pa   = pa;
    r.perm = perm;
    return r;
  endfunction

  // Table indexes crowd near the ends so that walks share table pages.
  function automatic logic [VPN_W-1:0] near_index();
    return ($urandom_range(0, 7) == 0) ? '1 : VPN_W'($urandom_range(0, 7));
  endfunction

  function automatic walk_req_t random_item();
    walk_req_t       r;
    logic [63:0]     raw;
    int              pick;
    pick = $urandom_range(0, 99);
    r.op   = 1'($urandom_range(0, 1));
    r.perm = PERM_W'($urandom);
    raw    = {$urandom, $urandom};
    r.pa   = {raw[PA_W-1:PG_SHIFT], {PG_SHIFT{1'b0}}};
    if (pick < 40 && shadow.mapped_va.size() != 0) begin
      r.va = shadow.mapped_va[$urandom_range(0, shadow.mapped_va.size() - 1)];
      if ($urandom_range(0, 1) == 1) r.va[PG_SHIFT +: VPN_W] = near_index();
    end else if (pick < 85) begin
      r.va = {near_index(), near_index(), near_index(), {PG_SHIFT{1'b0}}};
    end else begin
      raw  = {$urandom, $urandom};
      r.va = {raw[VA_W-1:PG_SHIFT], {PG_SHIFT{1'b0}}};
    end
    if (r.op == OP_LOOKUP || $urandom_range(0, 9) == 0) r.va[PG_SHIFT-1:0] = PG_SHIFT'($urandom);
    if (r.op == OP_MAP && $urandom_range(0, 19) == 0) r.pa[PG_SHIFT-1:0] = PG_SHIFT'($urandom);
    return r;
  endfunction

  task automatic send_word(walk_req_t r);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      repeat ($urandom_range(1, 12)) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= r;
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin : stimulus
    logic [PPN_W-1:0] base;
    int               ph;
    shadow      = new();
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    for (ph = 0; ph < PHASES; ph++) begin
      idle_odds = phase_odds[ph];
      case (ph)
        0, 5:    base = PPN_TOP - 1;
        1:       base = PPN_TOP;
        2:       base = '0;
        3:       base = PPN_W'({$urandom, $urandom});
        default: base = PPN_TOP - 2;
      endcase
      @(negedge clk);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= base;
      @(negedge clk);
      cfg_wr_en <= 1'b0;

      if (ph == 0) begin
        send_word(word(OP_LOOKUP, 39'h0, 56'h0, 8'h00));
        send_word(word(OP_MAP, 39'h1, 56'h0, 8'h02));
        send_word(word(OP_MAP, 39'h0, 56'hFFF, 8'h02));
        send_word(word(OP_MAP, 39'h0, 56'hFF_FFFF_FFFF_F000, 8'hFF));
        send_word(word(OP_LOOKUP, 39'h7FF, 56'h0, 8'h00));
        send_word(word(OP_MAP, 39'h0, 56'h1000, 8'h0E));
        send_word(word(OP_MAP, 39'h1000, 56'h0, 8'h00));
        send_word(word(OP_LOOKUP, 39'h1000, 56'h0, 8'h00));
        send_word(word(OP_MAP, 39'h1000, 56'h5000, 8'h02));
        send_word(word(OP_LOOKUP, 39'h2000, 56'h0, 8'h00));
        send_word(word(OP_MAP, 39'h7F_FFFF_F000, 56'h0, 8'h80));
        send_word(word(OP_LOOKUP, 39'h7F_FFFF_FFFF, 56'h0, 8'h00));
        send_word(word(OP_MAP, 39'h00_4000_0000, 56'h12_3456_789A_B000, 8'h0A));
        send_word(word(OP_MAP, 39'h00_8000_0000, 56'h7000, 8'h04));
        send_word(word(OP_MAP, 39'h00_8020_0000, 56'h8000, 8'h04));
        send_word(word(OP_LOOKUP, 39'h00_8000_0000, 56'h0, 8'h00));
        send_word(word(OP_LOOKUP, 39'h00_C000_0000, 56'h0, 8'h00));
        send_word(word(OP_MAP, 39'h00_C000_0000, 56'h9000, 8'h08));
        send_word(word(OP_MAP, 39'h00_0020_0000, 56'hA000, 8'h08));
        send_word(word(OP_MAP, 39'h3000, 56'h0000_0ABC_DEF0_0000, 8'h0F));
      end
      repeat (PHASE_WORDS) send_word(random_item());

      @(negedge clk);
      in_tvalid <= 1'b0;
      while (shadow.due.size() != 0) @(posedge clk);
      repeat (SETTLE) @(posedge clk);
    end

    if (shadow.errors == 0) begin
      $display("sv39_page_table_map_walk: match");
    end else begin
      $display("sv39_page_table_map_walk: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/sv39ptw_pkg.sv
hdl/sv39ptw_ram.sv
hdl/sv39ptw_dp.sv
hdl/sv39ptw_ctrl.sv
hdl/sv39_page_table_map_walk.sv
tb/sv/tb_sv39_walk_pkg.sv
tb/sv/tb_sv39_page_table_map_walk.sv
